[rtl/mac_control_element_parser_top_defines.svh]
// Assertion macros shared by the checker of the control element parser.
`ifndef MAC_CONTROL_ELEMENT_PARSER_TOP_DEFINES_SVH
`define MAC_CONTROL_ELEMENT_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MCEP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MCEP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcep_pkg.sv]
// Types and constants of the MAC control element parser.
`default_nettype none

package mcep_pkg;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_LBSR_MAP   = 3'd1,
    KIND_LBSR_ENTRY = 3'd2,
    KIND_SBSR       = 3'd3,
    KIND_PHR        = 3'd4,
    KIND_UNKNOWN    = 3'd5
  } kind_t;

  typedef enum logic [7:0] {
    PH_TYPE       = 8'b0000_0001,
    PH_LBSR_LEN   = 8'b0000_0010,
    PH_LBSR_MAP   = 8'b0000_0100,
    PH_LBSR_ENTRY = 8'b0000_1000,
    PH_SBSR       = 8'b0001_0000,
    PH_PHR1       = 8'b0010_0000,
    PH_PHR2       = 8'b0100_0000,
    PH_SKIP       = 8'b1000_0000
  } phase_t;

  localparam logic [5:0] TYPE_LONG_BSR  = 6'd62;
  localparam logic [5:0] TYPE_SHORT_BSR = 6'd61;
  localparam logic [5:0] TYPE_PHR       = 6'd57;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned TRUNC_BIT  = 44;

endpackage

`default_nettype wire

[rtl/mac_control_element_parser_top.sv]
// Top level of the uplink MAC control element parser (long BSR, short BSR, PHR).
// A result appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a result waits untaken.
// The output register lets a new byte in during the cycle its result is taken.
// Reset clears the parse phase, all counters and the output valid flag.
`default_nettype none

module mac_control_element_parser_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // data_byte [7:0], payload_length [13:8], zero [15:14]
  input  wire logic [mcep_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // first_of_payload [0]
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // group_field [7:0], entry_index [15:8], buffer_size [23:16],
  // power_headroom [29:24], reserved_bits [31:30], max_power_field [37:32],
  // type_code [43:38], truncated [44], zero [47:45]
  output logic [mcep_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // element_kind [2:0]
  output logic [2:0]                              m_axis_tuser,
  // payload_end
  output logic                                    m_axis_tlast
);

  mcep_pkg::phase_t parse_phase, phase_next, phase_in;
  logic [5:0] bytes_left, bytes_left_next, bytes_eff;
  logic [7:0] bsr_entries_left, entries_next, entries_dec;
  logic [7:0] bsr_entry_count, count_next;
  logic [5:0] saved_headroom, headroom_next;
  logic [5:0] current_type, type_next;

  logic [7:0] data_byte;
  logic [5:0] payload_length;
  logic       first_of_payload;
  logic       active, last, emit, accept;

  mcep_pkg::kind_t r_kind;
  logic [7:0] r_group, r_index, r_size;
  logic [5:0] r_ph, r_fc, r_type;
  logic [1:0] r_res;
  logic       r_trunc;

  assign data_byte        = s_axis_tdata[7:0];
  assign payload_length   = s_axis_tdata[13:8];
  assign first_of_payload = s_axis_tuser;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_in  = first_of_payload ? mcep_pkg::PH_TYPE : parse_phase;
    bytes_eff = first_of_payload ? ((payload_length == 6'd0) ? 6'd1 : payload_length)
                                 : bytes_left;
    active          = first_of_payload || (bytes_left != 6'd0);
    bytes_left_next = bytes_eff - 6'd1;
    last            = (bytes_eff == 6'd1);
    entries_dec     = bsr_entries_left - 8'd1;

    phase_next    = phase_in;
    entries_next  = bsr_entries_left;
    count_next    = bsr_entry_count;
    headroom_next = saved_headroom;
    type_next     = current_type;
    emit          = 1'b0;
    r_kind        = mcep_pkg::KIND_NONE;
    r_group       = 8'd0;
    r_index       = 8'd0;
    r_size        = 8'd0;
    r_ph          = 6'd0;
    r_res         = 2'd0;
    r_fc          = 6'd0;
    r_type        = 6'd0;
    r_trunc       = 1'b0;

    unique case (phase_in)
      mcep_pkg::PH_TYPE: begin
        type_next = data_byte[5:0];
        if (type_next == mcep_pkg::TYPE_LONG_BSR) begin
          phase_next = mcep_pkg::PH_LBSR_LEN;
        end else if (type_next == mcep_pkg::TYPE_SHORT_BSR) begin
          phase_next = mcep_pkg::PH_SBSR;
        end else if (type_next == mcep_pkg::TYPE_PHR) begin
          phase_next = mcep_pkg::PH_PHR1;
        end else begin
          r_kind     = mcep_pkg::KIND_UNKNOWN;
          r_type     = type_next;
          emit       = 1'b1;
          phase_next = mcep_pkg::PH_SKIP;
        end
      end
      mcep_pkg::PH_LBSR_LEN: begin
        entries_next = (data_byte >= 8'd2) ? data_byte - 8'd1 : 8'd0;
        phase_next   = mcep_pkg::PH_LBSR_MAP;
      end
      mcep_pkg::PH_LBSR_MAP: begin
        r_kind     = mcep_pkg::KIND_LBSR_MAP;
        r_group    = data_byte;
        r_type     = type_next;
        emit       = 1'b1;
        count_next = 8'd0;
        phase_next = (bsr_entries_left != 8'd0) ? mcep_pkg::PH_LBSR_ENTRY
                                                : mcep_pkg::PH_TYPE;
      end
      mcep_pkg::PH_LBSR_ENTRY: begin
        r_kind       = mcep_pkg::KIND_LBSR_ENTRY;
        r_index      = bsr_entry_count;
        r_size       = data_byte;
        r_type       = type_next;
        emit         = 1'b1;
        count_next   = bsr_entry_count + 8'd1;
        entries_next = entries_dec;
        if (entries_dec == 8'd0) begin
          phase_next = mcep_pkg::PH_TYPE;
        end
      end
      mcep_pkg::PH_SBSR: begin
        r_kind     = mcep_pkg::KIND_SBSR;
        r_group    = {5'd0, data_byte[7:5]};
        r_size     = {3'd0, data_byte[4:0]};
        r_type     = type_next;
        emit       = 1'b1;
        phase_next = mcep_pkg::PH_TYPE;
      end
      mcep_pkg::PH_PHR1: begin
        headroom_next = data_byte[5:0];
        phase_next    = mcep_pkg::PH_PHR2;
      end
      mcep_pkg::PH_PHR2: begin
        r_kind     = mcep_pkg::KIND_PHR;
        r_ph       = saved_headroom;
        r_res      = data_byte[7:6];
        r_fc       = data_byte[5:0];
        r_type     = type_next;
        emit       = 1'b1;
        phase_next = mcep_pkg::PH_TYPE;
      end
      mcep_pkg::PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (last) begin
      r_trunc = (phase_next != mcep_pkg::PH_TYPE) && (phase_next != mcep_pkg::PH_SKIP);
      if (!emit) begin
        unique case (phase_next)
          mcep_pkg::PH_LBSR_LEN, mcep_pkg::PH_LBSR_MAP: begin
            r_kind = mcep_pkg::KIND_LBSR_MAP;
            r_type = type_next;
          end
          mcep_pkg::PH_SBSR: begin
            r_kind = mcep_pkg::KIND_SBSR;
            r_type = type_next;
          end
          mcep_pkg::PH_PHR1: begin
            r_kind = mcep_pkg::KIND_PHR;
            r_type = type_next;
          end
          mcep_pkg::PH_PHR2: begin
            r_kind = mcep_pkg::KIND_PHR;
            r_ph   = headroom_next;
            r_type = type_next;
          end
          default: begin
          end
        endcase
      end
      emit       = 1'b1;
      phase_next = mcep_pkg::PH_TYPE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= mcep_pkg::PH_TYPE;
      bytes_left       <= 6'd0;
      bsr_entries_left <= 8'd0;
      bsr_entry_count  <= 8'd0;
      saved_headroom   <= 6'd0;
      current_type     <= 6'd0;
    end else if (accept && active) begin
      parse_phase      <= phase_next;
      bytes_left       <= bytes_left_next;
      bsr_entries_left <= entries_next;
      bsr_entry_count  <= count_next;
      saved_headroom   <= headroom_next;
      current_type     <= type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && active && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && emit) begin
      m_axis_tdata <= {3'd0, r_trunc, r_type, r_fc, r_res, r_ph, r_size, r_index, r_group};
      m_axis_tuser <= r_kind;
      m_axis_tlast <= last;
    end
  end

endmodule

`default_nettype wire

[rtl/mcep_checker.sv]
// Port-level checker of the control element parser and its bind.
`default_nettype none

`include "mac_control_element_parser_top_defines.svh"

module mcep_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [mcep_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [2:0]                     m_axis_tuser,
  input wire logic                           m_axis_tlast
);

  logic                            kind_none;
  logic                            trunc;
  logic                            stalled;
  logic [mcep_pkg::OUT_DATA_W+4:0] out_word;
  logic [5:0]                      code;
  logic                            known_code;
  logic                            out_none;
  logic                            none_ok;
  logic                            out_trunc;
  logic                            trunc_ok;
  logic                            out_unknown;
  logic                            unknown_ok;

  assign kind_none = (m_axis_tuser == mcep_pkg::KIND_NONE);
  assign trunc     = m_axis_tdata[mcep_pkg::TRUNC_BIT];
  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign code      = m_axis_tdata[43:38];

  assign known_code = (code == mcep_pkg::TYPE_LONG_BSR) || (code == mcep_pkg::TYPE_SHORT_BSR) ||
                      (code == mcep_pkg::TYPE_PHR);

  assign out_none    = m_axis_tvalid && kind_none;
  assign none_ok     = m_axis_tlast && (m_axis_tdata == '0);
  assign out_trunc   = m_axis_tvalid && trunc;
  assign trunc_ok    = m_axis_tlast && !kind_none;
  assign out_unknown = m_axis_tvalid && (m_axis_tuser == mcep_pkg::KIND_UNKNOWN);
  assign unknown_ok  = !trunc && !known_code;

  `MCEP_ASSERT_NEXT(a_out_hold, stalled, $stable(out_word), "Output item changed while stalled.")
  `MCEP_ASSERT_SAME(a_none_is_end, out_none, none_ok, "Empty item that does not close a payload.")
  `MCEP_ASSERT_SAME(a_trunc_is_end, out_trunc, trunc_ok, "Truncated item before the payload end.")
  `MCEP_ASSERT_SAME(a_unknown_whole, out_unknown, unknown_ok, "Known type reported as unknown.")

endmodule

bind mac_control_element_parser_top mcep_checker u_mcep_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/tb_mac_control_element_parser_top.sv]
// Self-checking testbench for the MAC control element parser with a built-in predictor.
module tb_mac_control_element_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcep_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned ITEM_TARGET = 1700;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] group;
    logic [7:0] index;
    logic [7:0] bsize;
    logic [5:0] headroom;
    logic [1:0] rbits;
    logic [5:0] maxpower;
    logic [5:0] tcode;
    logic       cut;
    logic       last;
  } element_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // Predictor state.
  phase_t     parse_state = PH_TYPE;
  logic [5:0] bytes_left = '0;
  logic [7:0] entries_left = '0;
  logic [7:0] entry_count = '0;
  logic [5:0] saved_headroom = '0;
  logic [5:0] cur_type = '0;

  element_report_t expected_reports[$];
  logic [7:0]      frame_bytes[$];

  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int hold_cycles = 0;
  int stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned payload_bytes = 0;
  int unsigned report_count = 0;
  int unsigned cut_count = 0;
  int unsigned kind_count[8];
  int unsigned failures = 0;

  mac_control_element_parser_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding", cycle_count,
               expected_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int idle_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic compare_field(input int unsigned n, input string name,
                               input logic [7:0] want, input logic [7:0] got);
    if (want !== got)
      note_failure($sformatf("Report %0d: %s expected 0x%0h, got 0x%0h", n, name, want, got));
  endtask

  // Works out the report, if any, caused by one accepted byte.
  task automatic parse_byte(input logic [7:0] b, input logic first, input logic [5:0] len);
    element_report_t r;
    logic emit;
    logic last;
    logic cut;
    r = '0;
    emit = 1'b0;
    if (first) begin
      bytes_left = (len == 6'd0) ? 6'd1 : len;
      parse_state = PH_TYPE;
    end else if (bytes_left == 6'd0) begin
      return;
    end
    bytes_left = bytes_left - 6'd1;
    last = (bytes_left == 6'd0);
    case (parse_state)
      PH_TYPE: begin
        cur_type = b[5:0];
        if (cur_type == TYPE_LONG_BSR) begin
          parse_state = PH_LBSR_LEN;
        end else if (cur_type == TYPE_SHORT_BSR) begin
          parse_state = PH_SBSR;
        end else if (cur_type == TYPE_PHR) begin
          parse_state = PH_PHR1;
        end else begin
          r.kind = KIND_UNKNOWN;
          r.tcode = cur_type;
          emit = 1'b1;
          parse_state = PH_SKIP;
        end
      end
      PH_LBSR_LEN: begin
        entries_left = (b >= 8'd2) ? b - 8'd1 : 8'd0;
        parse_state = PH_LBSR_MAP;
      end
      PH_LBSR_MAP: begin
        r.kind = KIND_LBSR_MAP;
        r.group = b;
        r.tcode = cur_type;
        emit = 1'b1;
        entry_count = 8'd0;
        parse_state = (entries_left != 8'd0) ? PH_LBSR_ENTRY : PH_TYPE;
      end
      PH_LBSR_ENTRY: begin
        r.kind = KIND_LBSR_ENTRY;
        r.index = entry_count;
        r.bsize = b;
        r.tcode = cur_type;
        emit = 1'b1;
        entry_count = entry_count + 8'd1;
        entries_left = entries_left - 8'd1;
        if (entries_left == 8'd0) parse_state = PH_TYPE;
      end
      PH_SBSR: begin
        r.kind = KIND_SBSR;
        r.group = {5'd0, b[7:5]};
        r.bsize = {3'd0, b[4:0]};
        r.tcode = cur_type;
        emit = 1'b1;
        parse_state = PH_TYPE;
      end
      PH_PHR1: begin
        saved_headroom = b[5:0];
        parse_state = PH_PHR2;
      end
      PH_PHR2: begin
        r.kind = KIND_PHR;
        r.headroom = saved_headroom;
        r.rbits = b[7:6];
        r.maxpower = b[5:0];
        r.tcode = cur_type;
        emit = 1'b1;
        parse_state = PH_TYPE;
      end
      default: ;
    endcase
    if (last) begin
      cut = (parse_state != PH_TYPE) && (parse_state != PH_SKIP);
      if (!emit) begin
        case (parse_state)
          PH_LBSR_LEN, PH_LBSR_MAP: begin
            r.kind = KIND_LBSR_MAP;
            r.tcode = cur_type;
          end
          PH_SBSR: begin
            r.kind = KIND_SBSR;
            r.tcode = cur_type;
          end
          PH_PHR1: begin
            r.kind = KIND_PHR;
            r.tcode = cur_type;
          end
          PH_PHR2: begin
            r.kind = KIND_PHR;
            r.headroom = saved_headroom;
            r.tcode = cur_type;
          end
          default: ;
        endcase
        emit = 1'b1;
      end
      r.cut = cut;
      r.last = 1'b1;
      parse_state = PH_TYPE;
    end
    if (emit) expected_reports.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [5:0] len);
    int gap;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {2'b00, len, b};
    s_axis_tuser = first;
    do @(posedge clk); while (!s_axis_tready);
    if (first || bytes_left != 6'd0) payload_bytes++;
    parse_byte(b, first, len);
    gap = (sender_idle && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // The length field of bytes after the first is meaningless and is randomised.
  task automatic send_frame(input int count, input logic [5:0] len);
    for (int i = 0; i < count; i++)
      send_byte(frame_bytes[i], i == 0, (i == 0) ? len : 6'($urandom_range(0, 63)));
  endtask

  task automatic build_payload();
    int want;
    int pick;
    int n;
    frame_bytes.delete();
    want = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 63);
    while (frame_bytes.size() < want) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        frame_bytes.push_back({2'($urandom_range(0, 3)), TYPE_LONG_BSR});
        if (n == 0) frame_bytes.push_back(8'($urandom_range(0, 1)));
        else if ($urandom_range(0, 99) < 5) frame_bytes.push_back(8'($urandom_range(0, 255)));
        else frame_bytes.push_back(8'(n + 1));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick <= 5) begin
        frame_bytes.push_back({2'($urandom_range(0, 3)), TYPE_SHORT_BSR});
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick <= 8) begin
        frame_bytes.push_back({2'($urandom_range(0, 3)), TYPE_PHR});
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        break;
      end
    end
    while (frame_bytes.size() > 63) void'(frame_bytes.pop_back());
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
      m_axis_tready = 1'b0;
      stall_left = idle_length() - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_reports
    element_report_t want;
    element_report_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = kind_t'(m_axis_tuser);
      got.group = m_axis_tdata[7:0];
      got.index = m_axis_tdata[15:8];
      got.bsize = m_axis_tdata[23:16];
      got.headroom = m_axis_tdata[29:24];
      got.rbits = m_axis_tdata[31:30];
      got.maxpower = m_axis_tdata[37:32];
      got.tcode = m_axis_tdata[43:38];
      got.cut = m_axis_tdata[TRUNC_BIT];
      got.last = m_axis_tlast;
      report_count++;
      if (expected_reports.size() == 0) begin
        note_failure($sformatf("Report %0d arrived with none expected (kind %0d)",
                               report_count, got.kind));
      end else begin
        want = expected_reports.pop_front();
        kind_count[want.kind]++;
        if (want.cut) cut_count++;
        compare_field(report_count, "element_kind", 8'(want.kind), 8'(got.kind));
        compare_field(report_count, "group_field", want.group, got.group);
        compare_field(report_count, "entry_index", want.index, got.index);
        compare_field(report_count, "buffer_size", want.bsize, got.bsize);
        compare_field(report_count, "power_headroom", 8'(want.headroom), 8'(got.headroom));
        compare_field(report_count, "reserved_bits", 8'(want.rbits), 8'(got.rbits));
        compare_field(report_count, "max_power_field", 8'(want.maxpower), 8'(got.maxpower));
        compare_field(report_count, "type_code", 8'(want.tcode), 8'(got.tcode));
        compare_field(report_count, "truncated", 8'(want.cut), 8'(got.cut));
        compare_field(report_count, "payload_end", 8'(want.last), 8'(got.last));
      end
    end
  end

  task automatic test_directed_cases();
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    send_byte(8'hFF, 1'b0, 6'h3F);
    send_byte(8'hFF, 1'b1, 6'd0);
    frame_bytes = '{8'h00, 8'hFF, 8'h55};
    send_frame(3, 6'd3);
    frame_bytes = '{8'hFD, 8'hFF};
    send_frame(2, 6'd2);
    frame_bytes = '{8'h79, 8'h3F, 8'hC0};
    send_frame(3, 6'd3);
    // Long BSR with two entries, then a short BSR cut off by the payload end.
    frame_bytes = '{8'hBE, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h3D};
    send_frame(6, 6'd6);
    frame_bytes = '{8'h3E, 8'h00, 8'hA5};
    send_frame(3, 6'd3);
    frame_bytes = '{8'h39, 8'h2A};
    send_frame(2, 6'd2);
    frame_bytes = '{8'h3E, 8'h05};
    send_frame(2, 6'd10);
    frame_bytes = '{8'h3D, 8'h00};
    send_frame(2, 6'd2);
  endtask

  task automatic test_output_backpressure();
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    frame_bytes.delete();
    frame_bytes.push_back(8'h3E);
    frame_bytes.push_back(8'd61);
    repeat (61) frame_bytes.push_back(8'($urandom_range(0, 255)));
    hold_cycles = 300;
    send_frame(63, 6'd63);
    hold_cycles = 150;
    send_frame(63, 6'd63);
  endtask

  task automatic test_random_payloads(input int unsigned upto, input bit idle_in,
                                      input bit idle_out);
    int pick;
    int cnt;
    sender_idle = idle_in;
    receiver_idle = idle_out;
    while (payload_bytes < upto) begin
      pick = $urandom_range(0, 99);
      build_payload();
      if (pick < 70) begin
        if (frame_bytes.size() == 1 && $urandom_range(0, 1) == 1) send_frame(1, 6'd0);
        else send_frame(frame_bytes.size(), 6'(frame_bytes.size()));
      end else if (pick < 80) begin
        send_frame(frame_bytes.size(), 6'($urandom_range(1, frame_bytes.size())));
      end else if (pick < 88) begin
        cnt = (frame_bytes.size() > 1) ? $urandom_range(1, frame_bytes.size() - 1) : 1;
        send_frame(cnt, 6'($urandom_range(cnt + 1, 63)));
      end else if (pick < 95) begin
        cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 63);
        frame_bytes.delete();
        repeat ((cnt == 0) ? 1 : cnt) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame(frame_bytes.size(), 6'(cnt));
      end else begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 6'($urandom_range(0, 63)));
      end
    end
  endtask

  task automatic wait_for_reports();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_cases();
    test_random_payloads(700, 1'b1, 1'b1);
    test_output_backpressure();
    test_random_payloads(1100, 1'b0, 1'b0);
    test_random_payloads(1400, 1'b1, 1'b0);
    test_random_payloads(ITEM_TARGET, 1'b0, 1'b1);
    wait_for_reports();
    if (expected_reports.size() != 0)
      note_failure($sformatf("%0d expected reports never arrived", expected_reports.size()));
    $display("Sent %0d payload bytes, checked %0d reports, %0d of them truncated.",
             payload_bytes, report_count, cut_count);
    $display("Reports by kind: none %0d, bitmap %0d, entry %0d, short %0d, PHR %0d, unknown %0d.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             kind_count[5]);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[mac_control_element_parser_top.f]
+incdir+rtl
rtl/mcep_pkg.sv
rtl/mac_control_element_parser_top.sv
rtl/mcep_checker.sv
tb/tb_mac_control_element_parser_top.sv
